### sv/srrc_pkg.sv
// Shared constants and types for the strided range run compressor.
package srrc_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 48;
    localparam int STRIDE_W   = 32;
    localparam int MIN_RUN_W  = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int ENTRY_W    = 2 * ADDR_W;

    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST    = 7'd8;
    localparam logic [STRIDE_W-1:0]  MAX_STRIDE_RST = 32'd8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RUN    = 1'b0,
        CFG_MAX_STRIDE = 1'b1
    } cfg_index_t;

    typedef logic [ADDR_W-1:0] addr_t;

endpackage

### sv/srrc_if.sv
// Handshake channels: input ranges and result items.
interface srrc_range_if;
    import srrc_pkg::*;
    logic  valid;
    logic  ready;
    addr_t range_start;
    addr_t range_end;
    logic  last_range;

    modport source (output valid, range_start, range_end, last_range, input ready);
    modport sink   (input valid, range_start, range_end, last_range, output ready);
endinterface

interface srrc_result_if;
    import srrc_pkg::*;
    logic                valid;
    logic                ready;
    logic                is_cyclic;
    addr_t               bound_start;
    addr_t               bound_end;
    addr_t               period_start;
    addr_t               period_end;
    logic [STRIDE_W-1:0] run_stride;
    logic                dropped;
    logic                last_out;

    modport source (output valid, is_cyclic, bound_start, bound_end, period_start,
                    period_end, run_stride, dropped, last_out, input ready);
    modport sink   (input valid, is_cyclic, bound_start, bound_end, period_start,
                    period_end, run_stride, dropped, last_out, output ready);
endinterface

### sv/srrc_ram.sv
// Generic one-write, one-read RAM with registered read data.
module srrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/strided_range_run_compressor.sv
// Strided range run compressor: top level with load, sort, scan and emit sequencer.
// Ranges are taken one per cycle into a 64-entry store while the list is open. The item
// marked last closes the list and the block drops ready until every result is taken.
// A short list is read back in arrival order, one result at a time, each held until taken.
// Otherwise a bubble sort over the single store read port runs, up to n passes (ends
// early on a pass with no swap), followed by two scans (check, then emit); a failed
// check replays the sorted list as linear.
module strided_range_run_compressor (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [srrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srrc_pkg::CFG_DATA_W-1:0] cfg_data,
    srrc_range_if.sink    range_in,
    srrc_result_if.source result_out
);
    import srrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_LD0, S_RDK, S_CMP, S_WRL,
        S_SRD, S_SEV, S_FIN, S_LRD, S_LEM, S_WAIT
    } state_t;

    state_t state_reg, ret_reg;

    logic [MIN_RUN_W-1:0] min_run_reg;
    logic [STRIDE_W-1:0]  max_stride_reg;
    logic [CNT_W-1:0]     count_reg, n_reg, k_reg, j_reg;
    logic                 ovf_reg, drop_reg, swapped_reg, have_reg, emit_pass_reg;
    addr_t                cur_s_reg, cur_e_reg;
    addr_t                st_reg, sz_reg, stride_reg, off_reg, lend_reg;

    logic                 out_valid_reg, out_cyc_reg, out_last_reg;
    addr_t                out_bs_reg, out_be_reg, out_ps_reg, out_pe_reg;
    logic [STRIDE_W-1:0]  out_st_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    srrc_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic             in_acc, full;
    logic [CNT_W-1:0] count_next;
    addr_t            e_start, e_end, e_size, diff, next_off, clip;
    logic             cur_gt, stride_ok;

    assign in_acc     = range_in.valid && range_in.ready;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign count_next = full ? count_reg : count_reg + 1'b1;

    assign e_start   = ram_rdata[ENTRY_W-1:ADDR_W];
    assign e_end     = ram_rdata[ADDR_W-1:0];
    assign e_size    = e_end - e_start;
    assign cur_gt    = (cur_s_reg > e_start) || ((cur_s_reg == e_start) && (cur_e_reg > e_end));
    assign diff      = e_start - st_reg;
    assign stride_ok = (diff != '0) && (diff <= ADDR_W'(max_stride_reg));
    assign next_off  = off_reg + stride_reg;
    assign clip      = (sz_reg > stride_reg) ? stride_reg : sz_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = {range_in.range_start, range_in.range_end};
        ram_raddr = k_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                ram_we = in_acc && !full;
            end
            S_RD0:
            begin
                ram_raddr = '0;
            end
            S_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(k_reg - 1'b1);
                ram_wdata = cur_gt ? ram_rdata : {cur_s_reg, cur_e_reg};
            end
            S_WRL:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(n_reg - 1'b1);
                ram_wdata = {cur_s_reg, cur_e_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign range_in.ready        = (state_reg == S_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.is_cyclic    = out_cyc_reg;
    assign result_out.bound_start  = out_bs_reg;
    assign result_out.bound_end    = out_be_reg;
    assign result_out.period_start = out_ps_reg;
    assign result_out.period_end   = out_pe_reg;
    assign result_out.run_stride   = out_st_reg;
    assign result_out.dropped      = drop_reg;
    assign result_out.last_out     = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            min_run_reg    <= MIN_RUN_RST;
            max_stride_reg <= MAX_STRIDE_RST;
            count_reg      <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            j_reg          <= '0;
            ovf_reg        <= 1'b0;
            drop_reg       <= 1'b0;
            swapped_reg    <= 1'b0;
            have_reg       <= 1'b0;
            emit_pass_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_cyc_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_MIN_RUN:    min_run_reg    <= cfg_data[MIN_RUN_W-1:0];
                    CFG_MAX_STRIDE: max_stride_reg <= cfg_data[STRIDE_W-1:0];
                    default:        ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (range_in.last_range)
                        begin
                            n_reg         <= count_next;
                            drop_reg      <= ovf_reg || full;
                            count_reg     <= '0;
                            ovf_reg       <= 1'b0;
                            k_reg         <= '0;
                            have_reg      <= 1'b0;
                            emit_pass_reg <= 1'b0;
                            if (count_next < CNT_W'(min_run_reg))
                            begin
                                state_reg <= S_LRD;
                            end
                            else if (count_next == CNT_W'(1))
                            begin
                                state_reg <= S_SRD;
                            end
                            else
                            begin
                                state_reg <= S_RD0;
                            end
                        end
                        else
                        begin
                            count_reg <= count_next;
                            ovf_reg   <= ovf_reg || full;
                        end
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_LD0;
                end
                S_LD0:
                begin
                    cur_s_reg   <= e_start;
                    cur_e_reg   <= e_end;
                    k_reg       <= CNT_W'(1);
                    swapped_reg <= 1'b0;
                    state_reg   <= S_RDK;
                end
                S_RDK:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    // keep the larger entry moving up
                    if (cur_gt)
                    begin
                        swapped_reg <= 1'b1;
                    end
                    else
                    begin
                        cur_s_reg <= e_start;
                        cur_e_reg <= e_end;
                    end
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg == n_reg - 1'b1) ? S_WRL : S_RDK;
                end
                S_WRL:
                begin
                    k_reg <= '0;
                    if (swapped_reg)
                    begin
                        state_reg <= S_RD0;
                    end
                    else
                    begin
                        state_reg <= S_SRD;
                    end
                end
                S_SRD:
                begin
                    state_reg <= (k_reg == n_reg) ? S_FIN : S_SEV;
                end
                S_SEV:
                begin
                    if (!have_reg)
                    begin
                        st_reg     <= e_start;
                        sz_reg     <= e_size;
                        j_reg      <= CNT_W'(1);
                        lend_reg   <= e_end;
                        stride_reg <= '0;
                        off_reg    <= '0;
                        have_reg   <= 1'b1;
                        k_reg      <= k_reg + 1'b1;
                        state_reg  <= S_SRD;
                    end
                    else if (j_reg == CNT_W'(1))
                    begin
                        // second entry fixes the stride
                        if (stride_ok)
                        begin
                            stride_reg <= diff;
                            if (e_size == sz_reg)
                            begin
                                j_reg     <= CNT_W'(2);
                                off_reg   <= diff;
                                lend_reg  <= e_end;
                                k_reg     <= k_reg + 1'b1;
                                state_reg <= S_SRD;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        else
                        begin
                            stride_reg <= '0;
                            state_reg  <= S_FIN;
                        end
                    end
                    else if ((e_size == sz_reg) && (diff == next_off))
                    begin
                        j_reg     <= j_reg + 1'b1;
                        off_reg   <= next_off;
                        lend_reg  <= e_end;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    have_reg <= 1'b0;
                    if (j_reg < CNT_W'(min_run_reg))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_LRD;
                    end
                    else if (emit_pass_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cyc_reg   <= 1'b1;
                        out_bs_reg    <= st_reg;
                        out_be_reg    <= lend_reg;
                        out_ps_reg    <= st_reg;
                        out_pe_reg    <= st_reg + clip;
                        out_st_reg    <= stride_reg[STRIDE_W-1:0];
                        out_last_reg  <= (k_reg == n_reg);
                        ret_reg       <= (k_reg == n_reg) ? S_IDLE : S_SRD;
                        state_reg     <= S_WAIT;
                    end
                    else if (k_reg == n_reg)
                    begin
                        // every run passed: rescan and emit
                        emit_pass_reg <= 1'b1;
                        k_reg         <= '0;
                        state_reg     <= S_SRD;
                    end
                    else
                    begin
                        state_reg <= S_SRD;
                    end
                end
                S_LRD:
                begin
                    state_reg <= S_LEM;
                end
                S_LEM:
                begin
                    out_valid_reg <= 1'b1;
                    out_cyc_reg   <= 1'b0;
                    out_bs_reg    <= e_start;
                    out_be_reg    <= e_end;
                    out_ps_reg    <= '0;
                    out_pe_reg    <= '0;
                    out_st_reg    <= '0;
                    out_last_reg  <= (k_reg == n_reg - 1'b1);
                    ret_reg       <= (k_reg == n_reg - 1'b1) ? S_IDLE : S_LRD;
                    k_reg         <= k_reg + 1'b1;
                    state_reg     <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (result_out.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
